>>> rtl/video_marker_square_overlay_defines.svh
// assertion macros shared by the overlay rtl
`ifndef VIDEO_MARKER_SQUARE_OVERLAY_DEFINES_SVH
`define VIDEO_MARKER_SQUARE_OVERLAY_DEFINES_SVH

// condition must hold in the same cycle
`define VMSQ_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vmsq assertion failed");

// condition must hold in the following cycle
`define VMSQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vmsq assertion failed");

`endif

>>> rtl/vmsq_pkg.sv
package vmsq_pkg;

    // field widths
    localparam int LUMA_W  = 8;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int MW_W    = 13;
    localparam int CNT_W   = 13;
    localparam int DCNT_W  = 7;
    localparam int WORD_W  = 64;
    localparam int OFS_W   = 12;

    // config port
    localparam int CFG_IDX_W = 4;

    // derived widths
    localparam int SQ_W      = CNT_W + 1;
    localparam int COLS_W    = SQ_W + MW_W;
    localparam int REQW_W    = COLS_W + 1;
    localparam int REQH_W    = MW_W + 1;
    localparam int RS_W      = COORD_W + 1;
    localparam int BIT_IDX_W = $clog2(WORD_W);

    // frame size saturation
    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

    // column divider: quotient bits resolved per stage
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = COORD_W / DIV_STEPS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MARKER_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MARKER_HEIGHT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_COUNT    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DATA_COUNT     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_DATA_WORD      = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_MARK_ENABLE    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_COL_START      = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LIFT       = CFG_IDX_W'(7);

    // marker colors
    localparam logic [LUMA_W-1:0] LUMA_BLACK = LUMA_W'(0);
    localparam logic [LUMA_W-1:0] LUMA_WHITE = LUMA_W'(255);

    // configuration plus values derived from it
    typedef struct packed {
        logic [MW_W-1:0]   marker_width;
        logic [MW_W-1:0]   marker_height;
        logic [CNT_W-1:0]  fixed_count;
        logic [DCNT_W-1:0] data_count;
        logic [WORD_W-1:0] data_word;
        logic              enable;
        logic [OFS_W-1:0]  col_start;
        logic [OFS_W-1:0]  row_lift;
        logic [SQ_W-1:0]   squares;
        logic [COLS_W-1:0] strip_cols;
        logic [REQW_W-1:0] req_w;
        logic [REQH_W-1:0] req_h;
    } t_cfg;

    // per-sample data carried beside the divider
    typedef struct packed {
        logic [LUMA_W-1:0]  luma;
        logic [COORD_W-1:0] x;
        logic               col_ge;
        logic [RS_W-1:0]    rs;
        logic [DIM_W-1:0]   fw;
        logic [DIM_W-1:0]   fh;
        logic               row_hit;
        logic               col_hit;
        logic               fit_err;
    } t_side;

    // restoring divider state: partial remainder, dividend shifting into quotient
    typedef struct packed {
        logic [MW_W-1:0]    rem;
        logic [COORD_W-1:0] qd;
    } t_div;

endpackage

>>> rtl/vmsq_if.sv
// pixel input channel
interface vmsq_pix_if import vmsq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LUMA_W-1:0]  luma_in;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;

    modport source (output valid, luma_in, pixel_col, pixel_row, frame_width, frame_height,
                    input ready);
    modport sink (input valid, luma_in, pixel_col, pixel_row, frame_width, frame_height,
                  output ready);
endinterface

// result channel
interface vmsq_res_if import vmsq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LUMA_W-1:0] luma_out;
    logic              fit_error;

    modport source (output valid, luma_out, fit_error, input ready);
    modport sink (input valid, luma_out, fit_error, output ready);
endinterface

// register write channel
interface vmsq_cfg_if import vmsq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/vmsq_cfg.sv
module vmsq_cfg import vmsq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vmsq_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    logic [MW_W-1:0]   r_marker_width;
    logic [MW_W-1:0]   r_marker_height;
    logic [CNT_W-1:0]  r_fixed_count;
    logic [DCNT_W-1:0] r_data_count;
    logic [WORD_W-1:0] r_data_word;
    logic              r_enable;
    logic [OFS_W-1:0]  r_col_start;
    logic [OFS_W-1:0]  r_row_lift;
    logic [SQ_W-1:0]   r_squares;
    logic [COLS_W-1:0] r_strip_cols;
    logic [REQW_W-1:0] r_req_w;
    logic [REQH_W-1:0] r_req_h;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_width  <= MW_W'(4);
            r_marker_height <= MW_W'(16);
            r_fixed_count   <= CNT_W'(4);
            r_data_count    <= DCNT_W'(5);
            r_data_word     <= WORD_W'(10);
            r_enable        <= 1'b1;
            r_col_start     <= '0;
            r_row_lift      <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_MARKER_WIDTH:  r_marker_width  <= i_cfg.data[MW_W-1:0];
                REG_MARKER_HEIGHT: r_marker_height <= i_cfg.data[MW_W-1:0];
                REG_FIXED_COUNT:   r_fixed_count   <= i_cfg.data[CNT_W-1:0];
                REG_DATA_COUNT:    r_data_count    <= i_cfg.data[DCNT_W-1:0];
                REG_DATA_WORD:     r_data_word     <= i_cfg.data;
                REG_MARK_ENABLE:   r_enable        <= i_cfg.data[0];
                REG_COL_START:     r_col_start     <= i_cfg.data[OFS_W-1:0];
                REG_ROW_LIFT:      r_row_lift      <= i_cfg.data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // strip extent: squares, then strip_cols, then req_w are registered in turn after a write
    always_ff @(posedge i_clk) begin
        r_squares    <= {1'b0, r_fixed_count} + {{(SQ_W-DCNT_W){1'b0}}, r_data_count};
        r_strip_cols <= {{(COLS_W-SQ_W){1'b0}}, r_squares}
                      * {{(COLS_W-MW_W){1'b0}}, r_marker_width};
        r_req_w      <= {1'b0, r_strip_cols} + {{(REQW_W-OFS_W){1'b0}}, r_col_start};
        r_req_h      <= {{(REQH_W-OFS_W){1'b0}}, r_row_lift} + {1'b0, r_marker_height};
    end

    always_comb begin
        o_cfg.marker_width  = r_marker_width;
        o_cfg.marker_height = r_marker_height;
        o_cfg.fixed_count   = r_fixed_count;
        o_cfg.data_count    = r_data_count;
        o_cfg.data_word     = r_data_word;
        o_cfg.enable        = r_enable;
        o_cfg.col_start     = r_col_start;
        o_cfg.row_lift      = r_row_lift;
        o_cfg.squares       = r_squares;
        o_cfg.strip_cols    = r_strip_cols;
        o_cfg.req_w         = r_req_w;
        o_cfg.req_h         = r_req_h;
    end

endmodule

>>> rtl/vmsq_front.sv
module vmsq_front import vmsq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    vmsq_pix_if.sink i_pix,
    input  t_cfg     i_cfg,
    output logic     o_valid,
    input  logic     i_ready,
    output t_side    o_side,
    output t_div     o_div
);

    logic  r_valid;
    t_side r_side;
    t_div  r_div;
    t_side n_side;
    t_div  n_div;

    assign i_pix.ready = !r_valid || i_ready;

    // clamp frame size, offset column and row by the strip origin
    always_comb begin
        n_side.luma    = i_pix.luma_in;
        n_side.fw      = (i_pix.frame_width > MAX_DIM) ? MAX_DIM : i_pix.frame_width;
        n_side.fh      = (i_pix.frame_height > MAX_DIM) ? MAX_DIM : i_pix.frame_height;
        n_side.col_ge  = i_pix.pixel_col >= i_cfg.col_start;
        n_side.x       = i_pix.pixel_col - i_cfg.col_start;
        n_side.rs      = {1'b0, i_pix.pixel_row} + {1'b0, i_cfg.row_lift};
        n_side.row_hit = 1'b0;
        n_side.col_hit = 1'b0;
        n_side.fit_err = 1'b0;
        n_div.rem      = '0;
        n_div.qd       = i_pix.pixel_col - i_cfg.col_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_side <= n_side;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule

>>> rtl/vmsq_div_stage.sv
module vmsq_div_stage import vmsq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_side           i_side,
    input  t_div            i_div,
    input  logic [MW_W-1:0] i_divisor,
    output logic            o_valid,
    input  logic            i_ready,
    output t_side           o_side,
    output t_div            o_div
);

    logic            r_valid;
    t_side           r_side;
    t_div            r_div;
    t_div            n_div;
    logic [MW_W:0]   rem_ext;
    logic            q_bit;

    assign o_ready = !r_valid || i_ready;

    // restoring division, a few quotient bits per stage
    always_comb begin
        n_div   = i_div;
        rem_ext = '0;
        q_bit   = 1'b0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            rem_ext = {n_div.rem, n_div.qd[COORD_W-1]};
            q_bit   = rem_ext >= {1'b0, i_divisor};
            if (q_bit) begin
                rem_ext = rem_ext - {1'b0, i_divisor};
            end
            n_div.rem = rem_ext[MW_W-1:0];
            n_div.qd  = {n_div.qd[COORD_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_side <= i_side;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule

>>> rtl/vmsq_out.sv
`include "video_marker_square_overlay_defines.svh"

module vmsq_out import vmsq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_side              i_side,
    input  logic [COORD_W-1:0] i_quot,
    input  t_cfg               i_cfg,
    vmsq_res_if.source         o_res
);

    logic              r_valid;
    logic [LUMA_W-1:0] r_luma;
    logic              r_fit;
    logic [LUMA_W-1:0] n_luma;
    logic              n_fit;
    logic              is_fixed;
    logic [LUMA_W-1:0] fixed_color;
    logic [LUMA_W-1:0] data_color;
    logic [SQ_W-1:0]   bit_idx;

    assign o_ready = !r_valid || o_res.ready;

    // square color from its index
    always_comb begin
        is_fixed    = {1'b0, i_quot} < i_cfg.fixed_count;
        fixed_color = i_quot[0] ? LUMA_WHITE : LUMA_BLACK;
        bit_idx     = i_cfg.squares - SQ_W'(1) - {{(SQ_W-COORD_W){1'b0}}, i_quot};
        if (bit_idx[SQ_W-1:BIT_IDX_W] != '0) begin
            data_color = LUMA_BLACK;
        end else begin
            data_color = i_cfg.data_word[bit_idx[BIT_IDX_W-1:0]] ? LUMA_WHITE : LUMA_BLACK;
        end
    end

    // pass, mark or flag the sample
    always_comb begin
        n_luma = i_side.luma;
        n_fit  = 1'b0;
        if (i_cfg.enable) begin
            if (i_side.fit_err) begin
                n_fit = 1'b1;
            end else if (i_side.row_hit && i_side.col_hit) begin
                n_luma = is_fixed ? fixed_color : data_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_luma <= n_luma;
            r_fit  <= n_fit;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.luma_out  = r_luma;
    assign o_res.fit_error = r_fit;

    // checks
    `VMSQ_ASSERT_NOW(a_fit_only_enabled, i_clk, i_rst_n, r_valid && r_fit, i_cfg.enable)
    `VMSQ_ASSERT_NEXT(a_load_shows_beat, i_clk, i_rst_n, i_valid && o_ready, r_valid)
    `VMSQ_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_valid && !o_res.ready, r_valid && $stable(r_luma) && $stable(r_fit))

endmodule

>>> rtl/video_marker_square_overlay.sv
// marker strip overlay for a luma pixel stream
//
// i_pix carries one luma sample per beat with its column, row and frame size;
// o_res returns one beat per input beat, in order: the sample unchanged, or
// black/white where it falls in the marker strip, plus the fit_error flag.
// i_cfg writes the eight registers by index; it is always ready. The user must
// write it only while no sample is in flight; the block does not enforce this.
// each result passes the input register, which loads on acceptance, then six
// divider stages and the output register before o_res offers it.
// throughput: one beat per cycle unless o_res stalls; the column to square-index
// division resolves two quotient bits per stage, so its six stages set the depth.
// reset clears every stage valid bit and loads the register defaults.
// when o_res is stalled each stage holds its beat and keeps accepting while
// a stage downstream of it is empty; nothing is dropped or repeated.
`include "video_marker_square_overlay_defines.svh"

module video_marker_square_overlay import vmsq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vmsq_cfg_if.sink   i_cfg,
    vmsq_pix_if.sink   i_pix,
    vmsq_res_if.source o_res
);

    // stage whose input gets the strip membership and fit checks
    localparam int CHECK_STAGE = 2;

    t_cfg  cfg;
    logic  stg_valid [0:DIV_STAGES];
    logic  stg_ready [0:DIV_STAGES];
    t_side stg_side  [0:DIV_STAGES];
    t_div  stg_div   [0:DIV_STAGES];

    function automatic t_side check_side(input t_side s, input t_cfg c);
        t_side r;
        r         = s;
        r.row_hit = (s.rs < s.fh)
                 && (({1'b0, s.rs} + {1'b0, c.marker_height}) >= {1'b0, s.fh});
        r.col_hit = s.col_ge && ({{(COLS_W-COORD_W){1'b0}}, s.x} < c.strip_cols);
        r.fit_err = (c.req_w > {{(REQW_W-DIM_W){1'b0}}, s.fw})
                 || (c.req_h > {{(REQH_W-DIM_W){1'b0}}, s.fh});
        return r;
    endfunction

    // register file
    vmsq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // input register
    vmsq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (cfg),
        .o_valid (stg_valid[0]),
        .i_ready (stg_ready[0]),
        .o_side  (stg_side[0]),
        .o_div   (stg_div[0])
    );

    // divider stages
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        t_side side_in;

        if (j == CHECK_STAGE) begin : g_chk
            assign side_in = check_side(stg_side[j], cfg);
        end else begin : g_pass
            assign side_in = stg_side[j];
        end

        vmsq_div_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (stg_valid[j]),
            .o_ready   (stg_ready[j]),
            .i_side    (side_in),
            .i_div     (stg_div[j]),
            .i_divisor (cfg.marker_width),
            .o_valid   (stg_valid[j+1]),
            .i_ready   (stg_ready[j+1]),
            .o_side    (stg_side[j+1]),
            .o_div     (stg_div[j+1])
        );
    end

    // color select and output register
    vmsq_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[DIV_STAGES]),
        .o_ready (stg_ready[DIV_STAGES]),
        .i_side  (stg_side[DIV_STAGES]),
        .i_quot  (stg_div[DIV_STAGES].qd),
        .i_cfg   (cfg),
        .o_res   (o_res)
    );

    // checks
    `VMSQ_ASSERT_NOW(a_drain_frees_input, i_clk, i_rst_n, o_res.ready, i_pix.ready)
    `VMSQ_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_pix.valid && i_pix.ready, stg_valid[0])
    `VMSQ_ASSERT_NOW(a_cfg_always_ready, i_clk, i_rst_n, 1'b1, i_cfg.ready)

endmodule
